### rtl/core/ppq_pkg.sv
// ----------------------------------------------------------------------------
// ppq_pkg
// Shared types and codes for the priority process queue: request and
// status codes, controller states, and the controller/datapath link.
// ----------------------------------------------------------------------------
package ppq_pkg;

    // Request codes
    typedef enum logic [1:0] {
        REQ_INSERT  = 2'd0,
        REQ_PEEK    = 2'd1,
        REQ_RM_HEAD = 2'd2,
        REQ_RM_ID   = 2'd3
    } req_t;

    // Reply status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2
    } st_t;

    // Controller states, one-hot
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_EVAL  = 4'b0100,
        S_REPLY = 4'b1000
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture request, set up scan
        logic rd;     // issue slot read
        logic eval;   // evaluate slot just read
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic done;   // request finished, reply registered
    } dstat_t;

endpackage

### rtl/core/ppq_req_if.sv
// ----------------------------------------------------------------------------
// ppq_req_if
// Request channel: valid/ready handshake with request payload.
// ----------------------------------------------------------------------------
interface ppq_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [3:0] proc_id;
    logic [7:0] prio;

    modport source (output valid, output req_type, output proc_id, output prio,
                    input ready);
    modport sink   (input valid, input req_type, input proc_id, input prio,
                    output ready);
endinterface

### rtl/core/ppq_rsp_if.sv
// ----------------------------------------------------------------------------
// ppq_rsp_if
// Reply channel: valid/ready handshake with reply payload.
// ----------------------------------------------------------------------------
interface ppq_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [3:0] out_id;
    logic [7:0] out_prio;
    logic [4:0] queue_count;

    modport source (output valid, output status, output out_id, output out_prio,
                    output queue_count, input ready);
    modport sink   (input valid, input status, input out_id, input out_prio,
                    input queue_count, output ready);
endinterface

### rtl/core/ppq_ctrl.sv
// ----------------------------------------------------------------------------
// ppq_ctrl
// Controller: sequences accept, slot read / evaluate loop and reply.
// ----------------------------------------------------------------------------
module ppq_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output ppq_pkg::cmd_t    cmd,
    input  ppq_pkg::dstat_t  stat
);

    ppq_pkg::state_t state_reg;
    ppq_pkg::state_t state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ppq_pkg::S_IDLE:
            begin
                if (in_valid)
                    state_next = ppq_pkg::S_READ;
            end
            ppq_pkg::S_READ:
                state_next = ppq_pkg::S_EVAL;
            ppq_pkg::S_EVAL:
            begin
                if (stat.done)
                    state_next = ppq_pkg::S_REPLY;
                else
                    state_next = ppq_pkg::S_READ;
            end
            ppq_pkg::S_REPLY:
            begin
                if (out_ready)
                    state_next = ppq_pkg::S_IDLE;
            end
            default:
                state_next = ppq_pkg::S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ppq_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // Handshake and commands
    assign in_ready  = (state_reg == ppq_pkg::S_IDLE);
    assign out_valid = (state_reg == ppq_pkg::S_REPLY);
    assign cmd.load  = in_ready && in_valid;
    assign cmd.rd    = (state_reg == ppq_pkg::S_READ);
    assign cmd.eval  = (state_reg == ppq_pkg::S_EVAL);

endmodule

### rtl/core/ppq_dp.sv
// ----------------------------------------------------------------------------
// ppq_dp
// Datapath: slot memory, entry count, scan index and reply registers.
// Insert shifts entries up from the tail until the slot for the new entry
// is reached; removals scan from the head and close the gap behind a hit.
// ----------------------------------------------------------------------------
module ppq_dp #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ppq_pkg::cmd_t    cmd,
    output ppq_pkg::dstat_t  stat,
    input  logic [1:0]       req_type,
    input  logic [3:0]       proc_id,
    input  logic [7:0]       prio,
    output logic [1:0]       status,
    output logic [3:0]       out_id,
    output logic [7:0]       out_prio,
    output logic [4:0]       queue_count
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // Slot memory
    logic [3:0]    mem_id   [QUEUE_DEPTH];
    logic [7:0]    mem_prio [QUEUE_DEPTH];

    // Request capture (payload)
    ppq_pkg::req_t req_reg;
    logic [3:0]    id_reg;
    logic [7:0]    prio_reg;

    // Read data
    logic [3:0]    rd_id_reg;
    logic [7:0]    rd_prio_reg;

    // Control state
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          found_reg, found_next;
    logic [3:0]    hit_id_reg, hit_id_next;
    logic [7:0]    hit_prio_reg, hit_prio_next;

    // Reply
    ppq_pkg::st_t  st_reg, st_next;
    logic [3:0]    oid_reg, oid_next;
    logic [7:0]    opr_reg, opr_next;

    // Scan helpers
    logic [CW-1:0] idx_m1;
    logic [AW-1:0] raddr;
    logic          is_ins;
    logic          full;
    logic          empty;
    logic          last;
    logic          take;
    logic          done;
    logic          we;
    logic [AW-1:0] waddr;
    logic [3:0]    wid;
    logic [7:0]    wprio;
    logic [CW+4:0] count_ext;

    assign idx_m1 = idx_reg - CW'(1);
    assign is_ins = (req_reg == ppq_pkg::REQ_INSERT);
    assign raddr  = is_ins ? idx_m1[AW-1:0] : idx_reg[AW-1:0];
    assign full   = (count_reg == CW'(QUEUE_DEPTH));
    assign empty  = (count_reg == '0);
    assign last   = (idx_reg == count_reg - CW'(1));
    assign take   = !found_reg &&
                    ((req_reg == ppq_pkg::REQ_RM_HEAD) || (rd_id_reg == id_reg));

    // Evaluate one slot
    always_comb
    begin
        done          = 1'b0;
        we            = 1'b0;
        waddr         = idx_reg[AW-1:0];
        wid           = rd_id_reg;
        wprio         = rd_prio_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        found_next    = found_reg;
        hit_id_next   = hit_id_reg;
        hit_prio_next = hit_prio_reg;
        st_next       = st_reg;
        oid_next      = oid_reg;
        opr_next      = opr_reg;

        if (cmd.load)
        begin
            idx_next   = (req_type == 2'(ppq_pkg::REQ_INSERT)) ? count_reg : '0;
            found_next = 1'b0;
        end
        else if (cmd.eval)
        begin
            case (req_reg)
                ppq_pkg::REQ_INSERT:
                begin
                    if (full)
                    begin
                        done     = 1'b1;
                        st_next  = ppq_pkg::ST_NOT_FOUND;
                        oid_next = '0;
                        opr_next = '0;
                    end
                    else if ((idx_reg == '0) || !(rd_prio_reg < prio_reg))
                    begin
                        // slot found: place the new entry
                        done       = 1'b1;
                        we         = 1'b1;
                        wid        = id_reg;
                        wprio      = prio_reg;
                        count_next = count_reg + CW'(1);
                        st_next    = ppq_pkg::ST_OK;
                        oid_next   = id_reg;
                        opr_next   = prio_reg;
                    end
                    else
                    begin
                        // lower priority: move it up one slot
                        we       = 1'b1;
                        idx_next = idx_m1;
                    end
                end
                ppq_pkg::REQ_PEEK:
                begin
                    done = 1'b1;
                    if (empty)
                    begin
                        st_next  = ppq_pkg::ST_EMPTY;
                        oid_next = '0;
                        opr_next = '0;
                    end
                    else
                    begin
                        st_next  = ppq_pkg::ST_OK;
                        oid_next = rd_id_reg;
                        opr_next = rd_prio_reg;
                    end
                end
                ppq_pkg::REQ_RM_HEAD,
                ppq_pkg::REQ_RM_ID:
                begin
                    if (empty)
                    begin
                        done     = 1'b1;
                        st_next  = ppq_pkg::ST_EMPTY;
                        oid_next = '0;
                        opr_next = '0;
                    end
                    else
                    begin
                        if (take)
                        begin
                            found_next    = 1'b1;
                            hit_id_next   = rd_id_reg;
                            hit_prio_next = rd_prio_reg;
                        end
                        else if (found_reg)
                        begin
                            // close the gap behind the hit
                            we    = 1'b1;
                            waddr = idx_m1[AW-1:0];
                        end

                        if (last)
                        begin
                            done = 1'b1;
                            if (found_reg || take)
                            begin
                                count_next = count_reg - CW'(1);
                                st_next    = ppq_pkg::ST_OK;
                                oid_next   = take ? rd_id_reg : hit_id_reg;
                                opr_next   = take ? rd_prio_reg : hit_prio_reg;
                            end
                            else
                            begin
                                st_next  = ppq_pkg::ST_NOT_FOUND;
                                oid_next = '0;
                                opr_next = '0;
                            end
                        end
                        else
                        begin
                            idx_next = idx_reg + CW'(1);
                        end
                    end
                end
                default:
                    done = 1'b1;
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
            found_reg <= found_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg  <= ppq_pkg::req_t'(req_type);
            id_reg   <= proc_id;
            prio_reg <= prio;
        end
        hit_id_reg   <= hit_id_next;
        hit_prio_reg <= hit_prio_next;
        st_reg       <= st_next;
        oid_reg      <= oid_next;
        opr_reg      <= opr_next;
    end

    // Slot memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_id[waddr]   <= wid;
            mem_prio[waddr] <= wprio;
        end
        if (cmd.rd)
        begin
            rd_id_reg   <= mem_id[raddr];
            rd_prio_reg <= mem_prio[raddr];
        end
    end

    // Outputs
    assign count_ext   = {5'b0, count_reg};
    assign stat.done   = done;
    assign status      = st_reg;
    assign out_id      = oid_reg;
    assign out_prio    = opr_reg;
    assign queue_count = count_ext[4:0];

endmodule

### rtl/core/priority_process_queue.sv
// ----------------------------------------------------------------------------
// priority_process_queue
// Ready queue of process identifiers in descending priority order, FIFO
// among equal priorities; insert, peek, remove-head and remove-by-id.
//
//   channel | dir | payload                                  | handshake
//   --------+-----+------------------------------------------+-----------
//   req     | in  | req_type[1:0] proc_id[3:0] prio[7:0]     | valid/ready
//   rsp     | out | status[1:0] out_id[3:0] out_prio[7:0]    | valid/ready
//           |     | queue_count[4:0]                         |
//
// One request at a time. Each slot visit is a slot read (S_READ) followed
// by an evaluate (S_EVAL); empty, full, peek and insert-at-tail requests
// visit one slot, longer scans up to QUEUE_DEPTH slots, between the accept
// in S_IDLE and the reply in S_REPLY. The reply is held until taken; a new
// request is accepted the cycle after the reply transfer. Reset empties
// the queue at once; slot contents are never cleared.
// ----------------------------------------------------------------------------
module priority_process_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    ppq_req_if.sink       req,
    ppq_rsp_if.source     rsp
);

    ppq_pkg::cmd_t   cmd;
    ppq_pkg::dstat_t stat;

    ppq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    ppq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .req_type    (req.req_type),
        .proc_id     (req.proc_id),
        .prio        (req.prio),
        .status      (rsp.status),
        .out_id      (rsp.out_id),
        .out_prio    (rsp.out_prio),
        .queue_count (rsp.queue_count)
    );

    // Only one request in flight
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !req.ready)
        else $error("request accepted while reply pending");

    // Every evaluate follows a slot read
    a_eval_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.eval |-> $past(cmd.rd))
        else $error("evaluate without preceding read");

    // Accepted request never replies in the next cycle
    a_no_early_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !rsp.valid)
        else $error("reply too early");

    // Failed replies carry zero identifier and priority
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status != 2'(ppq_pkg::ST_OK)))
            |-> ((rsp.out_id == '0) && (rsp.out_prio == '0)))
        else $error("non-ok reply with payload");

    // Status code is legal
    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> ((rsp.status == 2'(ppq_pkg::ST_OK)) ||
                       (rsp.status == 2'(ppq_pkg::ST_EMPTY)) ||
                       (rsp.status == 2'(ppq_pkg::ST_NOT_FOUND))))
        else $error("illegal status code");

endmodule
